/* sv/fwrs_pkg.sv */
// Package for the firmware image receive sequencer.
// Holds the phase, command and error codes and the CRC-32 byte update.
// No dependencies.
package fwrs_pkg;

  typedef enum logic [2:0] {
    PH_INIT     = 3'd0,
    PH_IDLE     = 3'd1,
    PH_OPENING  = 3'd2,
    PH_HEADER   = 3'd3,
    PH_BINARY   = 3'd4,
    PH_RENAMING = 3'd5,
    PH_DONE     = 3'd6,
    PH_ERROR    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_OPEN   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_CLOSE  = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_RENAME = 3'd5,
    CMD_DEINIT = 3'd6,
    CMD_RESET  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_INIT      = 3'd1,
    ERR_OPEN      = 3'd2,
    ERR_OVERRUN   = 3'd3,
    ERR_WRITE     = 3'd4,
    ERR_CHECKSUM  = 3'd5,
    ERR_RENAME    = 3'd6,
    ERR_UNUSED    = 3'd7
  } err_e;

  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam int unsigned MAX_RESULTS = 3;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/firmware_image_receive_sequencer.sv */
// Latency: results of a request appear the cycle after it is accepted, one result per cycle
// while out_stall_i is low. Throughput: one request per cycle when it yields one result and
// out_stall_i is low; two-result requests hold the input while the result buffer drains.
// A new request is taken in the cycle that the last pending result is taken.
// Reset (rst_ni low, asynchronous): phase init, no error, CRC all ones, no held byte.
//
// Firmware image receive sequencer: header capture, write commands, CRC-32 check.
// Depends on fwrs_pkg.
module firmware_image_receive_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       reply_ok_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] command_o,
  output logic [7:0] write_byte_o,
  output logic [2:0] phase_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  fwrs_pkg::phase_e phase_q, phase_d;
  fwrs_pkg::err_e   err_q, err_d;
  logic [3:0]       hdr_cnt_q, hdr_cnt_d;
  logic [31:0]      exp_len_q, exp_len_d;
  logic [31:0]      exp_crc_q, exp_crc_d;
  logic [31:0]      rcv_cnt_q, rcv_cnt_d;
  logic [31:0]      crc_q, crc_d;
  logic             held_v_q, held_v_d;
  logic [7:0]       held_b_q, held_b_d;

  fwrs_pkg::cmd_e   buf_cmd_q [fwrs_pkg::MAX_RESULTS];
  fwrs_pkg::cmd_e   new_cmd   [fwrs_pkg::MAX_RESULTS];
  logic [7:0]       buf_wb_q, new_wb;
  logic [1:0]       buf_cnt_q, new_cnt;

  logic             in_accept;
  logic             out_take;
  logic [31:0]      crc_new;
  logic [31:0]      rcv_new;

  assign out_valid_o  = (buf_cnt_q != 2'd0);
  assign out_take     = out_valid_o && !out_stall_i;
  assign in_stall_o   = (buf_cnt_q != 2'd0) && !((buf_cnt_q == 2'd1) && !out_stall_i);
  assign in_accept    = in_valid_i && !in_stall_o;

  assign command_o    = buf_cmd_q[0];
  assign write_byte_o = buf_wb_q;
  assign phase_o      = phase_q;
  assign error_code_o = err_q;
  assign last_o       = (buf_cnt_q == 2'd1);

  assign crc_new = fwrs_pkg::crc_fold(crc_q, held_b_q);
  assign rcv_new = rcv_cnt_q + 32'd1;

  always_comb begin
    logic [7:0] hb;
    logic [2:0] k;
    phase_d   = phase_q;
    err_d     = err_q;
    hdr_cnt_d = hdr_cnt_q;
    exp_len_d = exp_len_q;
    exp_crc_d = exp_crc_q;
    rcv_cnt_d = rcv_cnt_q;
    crc_d     = crc_q;
    held_v_d  = held_v_q;
    held_b_d  = held_b_q;
    for (int i = 0; i < fwrs_pkg::MAX_RESULTS; i++) begin
      new_cmd[i] = fwrs_pkg::CMD_NONE;
    end
    new_wb  = 8'd0;
    new_cnt = 2'd1;
    hb      = data_byte_i;
    k       = hdr_cnt_q[2:0];

    unique case (phase_q)
      fwrs_pkg::PH_INIT: begin
        if (opcode_i) begin
          if (reply_ok_i) begin
            phase_d = fwrs_pkg::PH_IDLE;
            if (held_v_q) begin
              new_cmd[0] = fwrs_pkg::CMD_OPEN;
              phase_d    = fwrs_pkg::PH_OPENING;
            end
          end else begin
            phase_d  = fwrs_pkg::PH_ERROR;
            err_d    = fwrs_pkg::ERR_INIT;
            held_v_d = 1'b0;
          end
        end else if (held_v_q) begin
          phase_d  = fwrs_pkg::PH_ERROR;
          err_d    = fwrs_pkg::ERR_OVERRUN;
          held_v_d = 1'b0;
        end else begin
          held_v_d = 1'b1;
          held_b_d = data_byte_i;
        end
      end
      fwrs_pkg::PH_IDLE: begin
        if (!opcode_i) begin
          held_v_d   = 1'b1;
          held_b_d   = data_byte_i;
          new_cmd[0] = fwrs_pkg::CMD_OPEN;
          phase_d    = fwrs_pkg::PH_OPENING;
        end
      end
      fwrs_pkg::PH_OPENING: begin
        if (opcode_i && reply_ok_i) begin
          // take the held byte as header byte zero
          held_v_d  = 1'b0;
          hdr_cnt_d = 4'd1;
          exp_len_d = {24'd0, held_b_q};
          exp_crc_d = 32'd0;
          phase_d   = fwrs_pkg::PH_HEADER;
        end else begin
          phase_d  = fwrs_pkg::PH_ERROR;
          err_d    = opcode_i ? fwrs_pkg::ERR_OPEN : fwrs_pkg::ERR_OVERRUN;
          held_v_d = 1'b0;
        end
      end
      fwrs_pkg::PH_HEADER: begin
        if (!opcode_i) begin
          for (int j = 0; j < 4; j++) begin
            if (k[1:0] == j[1:0]) begin
              if (!k[2]) begin
                exp_len_d[j*8 +: 8] = hb;
              end else begin
                exp_crc_d[j*8 +: 8] = hb;
              end
            end
          end
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (hdr_cnt_q >= 4'd7) begin
            rcv_cnt_d = 32'd0;
            crc_d     = fwrs_pkg::CRC_ONES;
            phase_d   = fwrs_pkg::PH_BINARY;
          end
        end
      end
      fwrs_pkg::PH_BINARY: begin
        if (!opcode_i) begin
          if (held_v_q) begin
            phase_d  = fwrs_pkg::PH_ERROR;
            err_d    = fwrs_pkg::ERR_OVERRUN;
            held_v_d = 1'b0;
          end else begin
            held_v_d   = 1'b1;
            held_b_d   = data_byte_i;
            new_cmd[0] = fwrs_pkg::CMD_WRITE;
            new_wb     = data_byte_i;
          end
        end else if (held_v_q) begin
          if (reply_ok_i) begin
            crc_d     = crc_new;
            rcv_cnt_d = rcv_new;
            held_v_d  = 1'b0;
            if (rcv_new >= exp_len_q) begin
              new_cmd[0] = fwrs_pkg::CMD_CLOSE;
              new_cnt    = 2'd2;
              if ((crc_new ^ fwrs_pkg::CRC_ONES) == exp_crc_q) begin
                new_cmd[1] = fwrs_pkg::CMD_RENAME;
                phase_d    = fwrs_pkg::PH_RENAMING;
              end else begin
                new_cmd[1] = fwrs_pkg::CMD_REMOVE;
                phase_d    = fwrs_pkg::PH_ERROR;
                err_d      = fwrs_pkg::ERR_CHECKSUM;
              end
            end
          end else begin
            phase_d  = fwrs_pkg::PH_ERROR;
            err_d    = fwrs_pkg::ERR_WRITE;
            held_v_d = 1'b0;
          end
        end
      end
      fwrs_pkg::PH_RENAMING: begin
        if (opcode_i) begin
          if (reply_ok_i) begin
            new_cmd[0] = fwrs_pkg::CMD_DEINIT;
            new_cmd[1] = fwrs_pkg::CMD_RESET;
            new_cnt    = 2'd2;
            phase_d    = fwrs_pkg::PH_DONE;
          end else begin
            phase_d  = fwrs_pkg::PH_ERROR;
            err_d    = fwrs_pkg::ERR_RENAME;
            held_v_d = 1'b0;
          end
        end
      end
      fwrs_pkg::PH_DONE,
      fwrs_pkg::PH_ERROR: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= fwrs_pkg::PH_INIT;
      err_q     <= fwrs_pkg::ERR_NONE;
      hdr_cnt_q <= 4'd0;
      exp_len_q <= 32'd0;
      exp_crc_q <= 32'd0;
      rcv_cnt_q <= 32'd0;
      crc_q     <= fwrs_pkg::CRC_ONES;
      held_v_q  <= 1'b0;
      held_b_q  <= 8'd0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      err_q     <= err_d;
      hdr_cnt_q <= hdr_cnt_d;
      exp_len_q <= exp_len_d;
      exp_crc_q <= exp_crc_d;
      rcv_cnt_q <= rcv_cnt_d;
      crc_q     <= crc_d;
      held_v_q  <= held_v_d;
      held_b_q  <= held_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= 2'd0;
    end else if (in_accept) begin
      buf_cnt_q <= new_cnt;
    end else if (out_take) begin
      buf_cnt_q <= buf_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int i = 0; i < fwrs_pkg::MAX_RESULTS; i++) begin
        buf_cmd_q[i] <= new_cmd[i];
      end
      buf_wb_q <= new_wb;
    end else if (out_take) begin
      for (int i = 0; i < fwrs_pkg::MAX_RESULTS - 1; i++) begin
        buf_cmd_q[i] <= buf_cmd_q[i+1];
      end
      buf_cmd_q[fwrs_pkg::MAX_RESULTS-1] <= fwrs_pkg::CMD_NONE;
      buf_wb_q <= 8'd0;
    end
  end

endmodule
